@@ hw/rtl/stg_pkg.sv @@
// Shared constants, types and the arctangent table of the sine tone generator.
`default_nettype none

package stg_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int RATE_BITS    = 20;
  localparam int TURN_BITS    = 32;
  localparam int TABLE_LEN    = 24;
  localparam int FRAC_BITS    = 30;

  localparam int CNT_W      = $clog2(TURN_BITS);
  localparam int XY_W       = FRAC_BITS + 4;
  localparam int Z_W        = TURN_BITS;
  localparam int PROD_W     = XY_W + SAMPLE_BITS - 1;
  localparam int Q_W        = PROD_W + 1 - FRAC_BITS;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] CFG_TONE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RATE = CFG_IDX_W'(1);

  localparam logic [RATE_BITS-1:0] TONE_RESET = RATE_BITS'(440);
  localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(48000);

  localparam logic [CNT_W-1:0] LAST_MOD = CNT_W'(RATE_BITS - 1);
  localparam logic [CNT_W-1:0] LAST_DIV = CNT_W'(TURN_BITS - 1);
  localparam logic [CNT_W-1:0] LAST_ROT = CNT_W'(CORDIC_STEPS - 1);

  localparam logic signed [XY_W-1:0] GAIN_Q30   = XY_W'(652032875);
  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [PROD_W-1:0]      HALF_LSB   = PROD_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [1:0] {
    SRC_TONE  = 2'd0,
    SRC_STEP  = 2'd1,
    SRC_PHASE = 2'd2
  } div_src_t;

  typedef struct packed {
    logic             flag_load;
    logic             div_load;
    div_src_t         div_src;
    logic             div_step;
    logic             step_wr;
    logic             phase_clear;
    logic             phase_wr;
    logic             turn_load;
    logic             cordic_load;
    logic             cordic_step;
    logic [CNT_W-1:0] idx;
    logic             fold;
    logic             mult;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic step_lt;
    logic phase_lt;
    logic out_free;
  } stat_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [Z_W-1:0] atan_turn(input logic [CNT_W-1:0] i);
    logic [Z_W-1:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sine_tone_generator.sv @@
// Top level of the sine tone generator: ports, sequencer and datapath.
//
//   Channel   Direction  Payload
//   cfg       in         cfg_index selects tone_frequency (0) or sample_rate (1)
//   s_axis    in         tdata[0] restart, tlast last_sample
//   m_axis    out        tdata[15:0] sample_value, tlast run_end
//
// A request goes from acceptance to the result register through the 32-step
// serial divide of the phase by the rate and the 16 CORDIC iterations;
// the next request can be taken in the cycle after the result is loaded.
// A restart or a step at or above a newly written rate adds the 20-step
// reduction by the rate, and a phase at or above it adds another such reduction.
// Reset is synchronous; the sequencer holds at the end only while the result register is full and not being taken.
`default_nettype none

module sine_tone_generator
  import stg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [RATE_BITS-1:0]   cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // [0] restart, rest zero
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // [15:0] sample_value
  output logic                   m_axis_tlast
);

  cmd_t                          cmd;
  stat_t                         status;
  logic signed [SAMPLE_BITS-1:0] sample_value;

  stg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .restart  (s_axis_tdata[0]),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  stg_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .last_sample  (s_axis_tlast),
    .out_ready    (m_axis_tready),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (m_axis_tvalid),
    .sample_value (sample_value),
    .run_end      (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_DATA_W'($unsigned(sample_value));

`ifndef ASSERT_OFF
  a_phase_reduced: assert property (@(posedge clk) disable iff (rst)
    cmd.turn_load |-> status.phase_lt)
    else $error("phase not reduced below the rate before the divide");

  a_phase_write_once: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.phase_clear, cmd.phase_wr, cmd.turn_load}))
    else $error("more than one phase update in one cycle");

  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result written while the output register is full");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !(cmd.div_step || cmd.cordic_step || cmd.out_load))
    else $error("datapath busy while a new request is taken");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/stg_ctrl.sv @@
// Sequencer of the sine tone generator: walks one request through reduce, divide, rotate, fold, multiply and round.
`default_nettype none

module stg_ctrl
  import stg_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  restart,
  output logic  in_ready,
  input  stat_t status,
  output cmd_t  cmd
);

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b000000000001,
    ST_STEP_MOD  = 12'b000000000010,
    ST_STEP_WR   = 12'b000000000100,
    ST_PHASE_CHK = 12'b000000001000,
    ST_PHASE_MOD = 12'b000000010000,
    ST_PHASE_WR  = 12'b000000100000,
    ST_TURN_DIV  = 12'b000001000000,
    ST_ROT_LOAD  = 12'b000010000000,
    ST_ROTATE    = 12'b000100000000,
    ST_FOLD      = 12'b001000000000,
    ST_MULT      = 12'b010000000000,
    ST_ROUND     = 12'b100000000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.idx    = cnt;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.flag_load = 1'b1;
          cnt_next      = '0;
          if (restart) begin
            cmd.phase_clear = 1'b1;
            cmd.div_load    = 1'b1;
            cmd.div_src     = SRC_TONE;
            state_next      = ST_STEP_MOD;
          end else if (!status.step_lt) begin
            cmd.div_load = 1'b1;
            cmd.div_src  = SRC_STEP;
            state_next   = ST_STEP_MOD;
          end else begin
            state_next = ST_PHASE_CHK;
          end
        end
      end
      ST_STEP_MOD: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == LAST_MOD) begin
          state_next = ST_STEP_WR;
        end
      end
      ST_STEP_WR: begin
        cmd.step_wr = 1'b1;
        state_next  = ST_PHASE_CHK;
      end
      ST_PHASE_CHK: begin
        cnt_next = '0;
        if (status.phase_lt) begin
          cmd.turn_load = 1'b1;
          state_next    = ST_TURN_DIV;
        end else begin
          cmd.div_load = 1'b1;
          cmd.div_src  = SRC_PHASE;
          state_next   = ST_PHASE_MOD;
        end
      end
      ST_PHASE_MOD: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == LAST_MOD) begin
          state_next = ST_PHASE_WR;
        end
      end
      ST_PHASE_WR: begin
        cmd.phase_wr = 1'b1;
        state_next   = ST_PHASE_CHK;
      end
      ST_TURN_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == LAST_DIV) begin
          state_next = ST_ROT_LOAD;
        end
      end
      ST_ROT_LOAD: begin
        cmd.cordic_load = 1'b1;
        cnt_next        = '0;
        state_next      = ST_ROTATE;
      end
      ST_ROTATE: begin
        cmd.cordic_step = 1'b1;
        cnt_next        = cnt + CNT_W'(1);
        if (cnt == LAST_ROT) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = ST_MULT;
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/stg_datapath.sv @@
// Datapath of the sine tone generator: registers, phase, serial divider, CORDIC and output.
`default_nettype none

module stg_datapath
  import stg_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [RATE_BITS-1:0]          cfg_data,
  input  logic                          last_sample,
  input  logic                          out_ready,
  input  cmd_t                          cmd,
  output stat_t                         status,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] sample_value,
  output logic                          run_end
);

  logic [RATE_BITS-1:0]          tone_frequency;
  logic [RATE_BITS-1:0]          sample_rate;
  logic [RATE_BITS-1:0]          phase_count;
  logic [RATE_BITS-1:0]          phase_step;
  logic [RATE_BITS-1:0]          step_red;
  logic                          step_only;
  logic [RATE_BITS-1:0]          rem;
  logic [TURN_BITS-1:0]          num;
  logic signed [XY_W-1:0]        x, y;
  logic signed [Z_W-1:0]         z;
  logic [1:0]                    quad;
  logic [XY_W-1:0]               mag;
  logic                          neg;
  logic [PROD_W-1:0]             prod;
  logic                          run_flag;

  logic [RATE_BITS-1:0]          sr_eff;
  logic [RATE_BITS-1:0]          div_src_val;
  logic [RATE_BITS:0]            trial;
  logic                          trial_ge;
  logic [RATE_BITS-1:0]          rem_next;
  logic [RATE_BITS-1:0]          step_use;
  logic [RATE_BITS:0]            phase_sum;
  logic [RATE_BITS-1:0]          phase_next;
  logic signed [XY_W-1:0]        dx, dy;
  logic signed [Z_W-1:0]         dz;
  logic signed [XY_W-1:0]        folded;
  logic [PROD_W:0]               rsum;
  logic [Q_W-1:0]                q;
  logic [SAMPLE_BITS-1:0]        q_sat;

  assign sr_eff = (sample_rate == '0) ? RATE_BITS'(1) : sample_rate;

  assign status.step_lt  = phase_step < sr_eff;
  assign status.phase_lt = phase_count < sr_eff;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_frequency <= TONE_RESET;
      sample_rate    <= RATE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TONE) begin
        tone_frequency <= cfg_data;
      end else if (cfg_index == CFG_RATE) begin
        sample_rate <= cfg_data;
      end
    end
  end

  always_comb begin
    unique case (cmd.div_src)
      SRC_TONE:  div_src_val = tone_frequency;
      SRC_STEP:  div_src_val = phase_step;
      SRC_PHASE: div_src_val = phase_count;
      default:   div_src_val = '0;
    endcase
  end

  // One restoring step: shift in the next numerator bit, subtract the rate if it fits.
  assign trial    = {rem, num[TURN_BITS-1]};
  assign trial_ge = trial >= {1'b0, sr_eff};
  assign rem_next = trial_ge ? RATE_BITS'(trial - {1'b0, sr_eff}) : trial[RATE_BITS-1:0];

  // The stored step stays as loaded at restart; a step at or above the rate is
  // reduced into a separate register for the current request only.
  assign step_use   = status.step_lt ? phase_step : step_red;
  assign phase_sum  = {1'b0, phase_count} + {1'b0, step_use};
  assign phase_next = (phase_sum >= {1'b0, sr_eff}) ?
                      RATE_BITS'(phase_sum - {1'b0, sr_eff}) : phase_sum[RATE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
      phase_step  <= '0;
      step_red    <= '0;
    end else begin
      if (cmd.phase_clear) begin
        phase_count <= '0;
      end else if (cmd.phase_wr) begin
        phase_count <= rem;
      end else if (cmd.turn_load) begin
        phase_count <= phase_next;
      end
      if (cmd.step_wr) begin
        if (step_only) begin
          step_red <= rem;
        end else begin
          phase_step <= rem;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem       <= '0;
      num       <= {div_src_val, {(TURN_BITS - RATE_BITS){1'b0}}};
      step_only <= (cmd.div_src == SRC_STEP);
    end else if (cmd.turn_load) begin
      rem <= phase_count;
      num <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_next;
      num <= {num[TURN_BITS-2:0], trial_ge};
    end
  end

  assign dx = y >>> cmd.idx;
  assign dy = x >>> cmd.idx;
  assign dz = $signed(atan_turn(cmd.idx));

  always_ff @(posedge clk) begin
    if (cmd.cordic_load) begin
      quad <= num[TURN_BITS-1 -: 2];
      z    <= $signed({2'b00, num[TURN_BITS-3:0]});
      x    <= GAIN_Q30;
      y    <= '0;
    end else if (cmd.cordic_step) begin
      if (!z[Z_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - dz;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + dz;
      end
    end
  end

  always_comb begin
    unique case (quad)
      2'd0: folded = y;
      2'd1: folded = x;
      2'd2: folded = -y;
      2'd3: folded = -x;
      default: folded = y;
    endcase
  end

  assign rsum  = {1'b0, prod} + {1'b0, HALF_LSB};
  assign q     = rsum[PROD_W:FRAC_BITS];
  assign q_sat = (q > Q_W'(FULL_SCALE)) ? FULL_SCALE : q[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.flag_load) begin
      run_flag <= last_sample;
    end
    if (cmd.fold) begin
      neg <= folded[XY_W-1];
      mag <= folded[XY_W-1] ? XY_W'(-folded) : XY_W'(folded);
    end
    if (cmd.mult) begin
      prod <= PROD_W'(mag) * PROD_W'(FULL_SCALE);
    end
    if (cmd.out_load) begin
      sample_value <= neg ? $signed(-q_sat) : $signed(q_sat);
      run_end      <= run_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_sine_tone_generator.sv @@
// Self-checking testbench for the sine tone generator: directed and random stream traffic against a predictor.
`default_nettype none

module tb_sine_tone_generator;
  import stg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam longint SAMPLE_FULL = (longint'(1) << (SAMPLE_BITS - 1)) - 1;

  typedef struct packed {
    logic restart;
    logic run_last;
  } tone_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          run_end;
  } tone_res_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TONE;
  logic [RATE_BITS-1:0]  cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [0] restart, rest zero
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // [15:0] sample_value
  logic                  m_axis_tlast;

  sine_tone_generator DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Arctangent of 2^-i in units of 2^-32 turn.
  longint atan_turns [0:15] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  logic [RATE_BITS-1:0] tone_hz = TONE_RESET;
  logic [RATE_BITS-1:0] rate_sps = RATE_RESET;
  logic [RATE_BITS-1:0] phase_acc = '0;
  logic [RATE_BITS-1:0] phase_inc = '0;

  tone_req_t   pending_requests[$];
  tone_res_t   expected_samples[$];
  tone_req_t   in_flight;
  tone_res_t   oldest_sample;
  int          gap_left = 0;
  int          burst_left = 1;
  int          ready_hold = 0;
  int          fail_count = 0;
  int unsigned cycle_count = 0;

  function automatic longint sine_q30(input logic [31:0] angle);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = longint'(GAIN_Q30);
    y = 0;
    z = longint'(angle[29:0]);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_turns[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_turns[i];
      end
    end
    case (angle[31:30])
      2'd0:    return y;
      2'd1:    return x;
      2'd2:    return -y;
      default: return -x;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] to_q15(input longint s);
    longint unsigned mag;
    longint unsigned q;
    mag = (s < 0) ? longint'(-s) : s;
    q = (mag * SAMPLE_FULL + (longint'(1) << 29)) >> 30;
    if (q > SAMPLE_FULL) q = SAMPLE_FULL;
    return (s < 0) ? SAMPLE_BITS'(-q) : SAMPLE_BITS'(q);
  endfunction

  task automatic predict_sample(input tone_req_t r);
    longint unsigned rate;
    longint unsigned pos;
    longint unsigned inc;
    longint unsigned angle;
    longint unsigned nxt;
    tone_res_t res;
    rate = (rate_sps == '0) ? 1 : rate_sps;
    if (r.restart) begin
      phase_acc = '0;
      phase_inc = RATE_BITS'(tone_hz % rate);
    end
    pos = phase_acc % rate;
    inc = phase_inc % rate;
    angle = (pos << 32) / rate;
    res.sample_value = to_q15(sine_q30(angle[31:0]));
    res.run_end = r.run_last;
    nxt = pos + inc;
    if (nxt >= rate) nxt -= rate;
    phase_acc = RATE_BITS'(nxt);
    expected_samples.push_back(res);
  endtask

  function automatic void push_request(input logic restart, input logic run_last);
    tone_req_t r;
    r.restart = restart;
    r.run_last = run_last;
    pending_requests.push_back(r);
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_samples.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_BITS-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TONE) tone_hz = value;
    else rate_sps = value;
  endtask

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left <= 0;
      burst_left <= 1;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) predict_sample(in_flight);
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        in_flight = pending_requests.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_DATA_W'(in_flight.restart);
        s_axis_tlast <= in_flight.run_last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          m_axis_tready <= 1'b1;
          ready_hold <= $urandom_range(20, 300);
        end
        8, 9: begin
          m_axis_tready <= 1'b0;
          ready_hold <= $urandom_range(40, 140);
        end
        default: begin
          m_axis_tready <= ~m_axis_tready;
          ready_hold <= $urandom_range(0, 6);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_samples.size() == 0) begin
        $error("sample with no request waiting: sample_value %0d run_end %0b",
               $signed(m_axis_tdata[SAMPLE_BITS-1:0]), m_axis_tlast);
        fail_count++;
      end else begin
        oldest_sample = expected_samples.pop_front();
        if (m_axis_tdata[SAMPLE_BITS-1:0] !== oldest_sample.sample_value) begin
          $error("sample_value mismatch: expected %0d, actual %0d",
                 oldest_sample.sample_value, $signed(m_axis_tdata[SAMPLE_BITS-1:0]));
          fail_count++;
        end
        if (m_axis_tlast !== oldest_sample.run_end) begin
          $error("run_end mismatch: expected %0b, actual %0b",
                 oldest_sample.run_end, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [RATE_BITS-1:0] tone_v;
    logic [RATE_BITS-1:0] rate_v;
    int queued;
    int run_len;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // With no restart since reset the step is zero, so the output stays at zero.
    push_request(1'b0, 1'b0);
    push_request(1'b0, 1'b1);
    wait_idle();

    push_request(1'b1, 1'b0);
    push_request(1'b0, 1'b0);
    push_request(1'b0, 1'b1);
    wait_idle();

    // Quarter-turn steps land exactly on the quadrant boundaries.
    write_reg(CFG_TONE, 20'd12000);
    write_reg(CFG_RATE, 20'd48000);
    push_request(1'b1, 1'b0);
    push_request(1'b0, 1'b0);
    push_request(1'b0, 1'b0);
    push_request(1'b0, 1'b0);
    push_request(1'b0, 1'b1);
    wait_idle();

    write_reg(CFG_TONE, 20'd0);
    push_request(1'b1, 1'b1);
    wait_idle();

    write_reg(CFG_TONE, 20'hFFFFF);
    write_reg(CFG_RATE, 20'd1000);
    push_request(1'b1, 1'b0);
    push_request(1'b0, 1'b1);
    wait_idle();

    write_reg(CFG_RATE, 20'd0);
    push_request(1'b1, 1'b0);
    push_request(1'b0, 1'b1);
    wait_idle();

    write_reg(CFG_RATE, 20'hFFFFF);
    push_request(1'b1, 1'b1);
    wait_idle();

    // The phase runs up near a full turn, then the rate shrinks under it without a restart.
    write_reg(CFG_TONE, 20'hFFFFE);
    push_request(1'b1, 1'b0);
    push_request(1'b0, 1'b0);
    push_request(1'b0, 1'b0);
    wait_idle();
    write_reg(CFG_RATE, 20'd1000);
    push_request(1'b0, 1'b0);
    push_request(1'b0, 1'b1);
    wait_idle();

    write_reg(CFG_TONE, 20'd1);
    write_reg(CFG_RATE, 20'd1);
    push_request(1'b1, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 11; ph++) begin
      case ($urandom_range(0, 4))
        0:       rate_v = RATE_BITS'($urandom_range(1, 64));
        1:       rate_v = 20'hFFFFF;
        2:       rate_v = RATE_BITS'($urandom_range(0, 20'hFFFFF));
        default: rate_v = RATE_BITS'($urandom_range(8000, 192000));
      endcase
      case ($urandom_range(0, 5))
        0:       tone_v = RATE_BITS'($urandom_range(1, 2000));
        1:       tone_v = rate_v >> 2;
        2:       tone_v = RATE_BITS'($urandom_range(0, 20'hFFFFF));
        3:       tone_v = 20'hFFFFF;
        default: tone_v = RATE_BITS'($urandom_range(1, rate_v / 2 + 1));
      endcase
      write_reg(CFG_RATE, rate_v);
      if ($urandom_range(0, 3) != 0) write_reg(CFG_TONE, tone_v);
      queued = 0;
      while (queued < 36) begin
        if ($urandom_range(0, 6) != 0) begin
          run_len = $urandom_range(1, 12);
          for (int k = 0; k < run_len; k++) push_request(k == 0, k == run_len - 1);
          queued += run_len;
        end else begin
          push_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          queued++;
        end
      end
      wait_idle();
    end

    repeat (150) @(posedge clk);
    if (expected_samples.size() != 0) begin
      $error("%0d expected samples never arrived", expected_samples.size());
      fail_count++;
    end
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/stg_pkg.sv
hw/rtl/stg_ctrl.sv
hw/rtl/stg_datapath.sv
hw/rtl/sine_tone_generator.sv
tb/tb_sine_tone_generator.sv
